@@ rtl/core/scfla_pkg.sv @@
`default_nettype none

package scfla_pkg;

   localparam int ARENA_BYTES      = 65536;
   localparam int ALIGN_BYTES      = 16;
   localparam int MAX_POOLED_BYTES = 256;

   localparam int SIZE_W  = 17;
   localparam int ADDR_W  = 16;
   localparam int STAT_W  = 3;
   localparam int PHASE_W = 4;

   localparam int ALIGN_LG    = $clog2(ALIGN_BYTES);
   localparam int NUM_CLASSES = MAX_POOLED_BYTES / ALIGN_BYTES;
   localparam int CLASS_W     = $clog2(NUM_CLASSES);
   localparam int UNIT_W      = ADDR_W - ALIGN_LG;
   localparam int LINK_DEPTH  = 2 ** UNIT_W;
   localparam int HEAD_W      = UNIT_W + 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SIZE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_CAPACITY   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_BASE_PHASE = 1'b1;

   localparam logic [SIZE_W-1:0] CAPACITY_RESET = SIZE_W'(ARENA_BYTES);
   localparam logic [SIZE_W-1:0] ARENA_LIMIT    = SIZE_W'(ARENA_BYTES);
   localparam logic [SIZE_W-1:0] POOLED_LIMIT   = SIZE_W'(MAX_POOLED_BYTES);

   localparam logic [STAT_W-1:0] STAT_REUSED  = 3'd0;
   localparam logic [STAT_W-1:0] STAT_FRESH   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_OOM     = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FREED   = 3'd3;
   localparam logic [STAT_W-1:0] STAT_IGNORED = 3'd4;
   localparam logic [STAT_W-1:0] STAT_BADSIZE = 3'd5;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_FREE,
      OP_BAD,
      OP_IGNORE
   } op_kind_type;

   typedef struct packed {
      op_kind_type             kind;
      logic                    pooled;
      logic [CLASS_W-1:0]      cls;
      logic [SIZE_W-1:0]       size;
      logic [UNIT_W-1:0]       unit;
   } item_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  capacity;
      logic [PHASE_W-1:0] phase;
   } cfg_type;

endpackage

`default_nettype wire

@@ rtl/core/scfla_front.sv @@
`default_nettype none

module scfla_front (
   input  wire logic                         start,
   input  wire logic                         queue_full,
   input  wire logic                         req_command,
   input  wire logic [scfla_pkg::SIZE_W-1:0] req_block_size,
   input  wire logic [scfla_pkg::ADDR_W-1:0] req_block_address,
   input  wire logic                         req_has_block,
   output logic                              busy,
   output logic                              push,
   output scfla_pkg::item_type               push_item
);
   import scfla_pkg::*;

   logic size_ok;
   logic pooled;

   always_comb begin
      size_ok = (req_block_size != '0) && (req_block_size[ALIGN_LG-1:0] == '0);
      pooled  = (req_block_size <= POOLED_LIMIT);
      busy    = queue_full;
      push    = start && !queue_full;

      push_item.pooled = pooled;
      push_item.cls    = req_block_size[ALIGN_LG +: CLASS_W] - CLASS_W'(1);
      push_item.size   = req_block_size;
      push_item.unit   = req_block_address[ADDR_W-1:ALIGN_LG];

      if (req_command == CMD_ALLOC) begin
         push_item.kind = size_ok ? OP_ALLOC : OP_BAD;
      end else if (!req_has_block || !pooled) begin
         push_item.kind = OP_IGNORE;
      end else if (!size_ok) begin
         push_item.kind = OP_BAD;
      end else begin
         push_item.kind = OP_FREE;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/scfla_queue.sv @@
`default_nettype none

module scfla_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire scfla_pkg::item_type push_item,
   input  wire logic                pop,
   output logic                     full,
   output logic                     not_empty,
   output scfla_pkg::item_type      head_item
);
   import scfla_pkg::*;

   item_type   entry_ff [2];
   item_type   entry_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_item;
         wr_ptr_in           = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
      full      = (count_ff == 2'd2);
      not_empty = (count_ff != 2'd0);
      head_item = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/scfla_back.sv @@
`default_nettype none

module scfla_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire scfla_pkg::cfg_type           cfg,
   input  wire logic                         item_valid,
   input  wire scfla_pkg::item_type          item,
   output logic                              pop,
   output logic                              rsp_valid,
   output logic [scfla_pkg::ADDR_W-1:0]      rsp_result_address,
   output logic [scfla_pkg::STAT_W-1:0]      rsp_status
);
   import scfla_pkg::*;

   typedef enum logic [1:0] {
      BK_EXEC = 2'b01,
      BK_LINK = 2'b10
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [HEAD_W-1:0] heads_ff [NUM_CLASSES];
   logic [HEAD_W-1:0] heads_in [NUM_CLASSES];
   logic [SIZE_W-1:0] bump_ff, bump_in;
   logic [CLASS_W-1:0] cls_ff, cls_in;
   logic [UNIT_W-1:0] unit_ff, unit_in;
   logic              valid_ff, valid_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [STAT_W-1:0] stat_ff, stat_in;

   logic [HEAD_W-1:0] link_mem [LINK_DEPTH];
   logic [HEAD_W-1:0] link_rd_ff;
   logic [UNIT_W-1:0] link_rd_addr;
   logic              link_we;
   logic [UNIT_W-1:0] link_wr_addr;
   logic [HEAD_W-1:0] link_wr_data;

   logic [HEAD_W-1:0]  head_rd;
   logic [PHASE_W-1:0] pad_zero;
   logic [PHASE_W-1:0] pad_bump;
   logic [SIZE_W:0]    start_pos;
   logic [SIZE_W-1:0]  cap;
   logic [SIZE_W:0]    room;
   logic [SIZE_W:0]    bump_end;
   logic               oom;

   always_comb begin
      head_rd   = heads_ff[item.cls];
      pad_zero  = PHASE_W'(0) - cfg.phase;
      pad_bump  = PHASE_W'(0) - (cfg.phase + bump_ff[PHASE_W-1:0]);
      start_pos = {1'b0, bump_ff} + (SIZE_W+1)'(pad_bump);
      cap       = (cfg.capacity > ARENA_LIMIT) ? ARENA_LIMIT : cfg.capacity;
      room      = {1'b0, cap} - start_pos;
      oom       = (start_pos > {1'b0, cap}) || ({1'b0, item.size} > room);
      bump_end  = start_pos + {1'b0, item.size};

      state_in     = state_ff;
      heads_in     = heads_ff;
      bump_in      = bump_ff;
      cls_in       = cls_ff;
      unit_in      = unit_ff;
      valid_in     = 1'b0;
      addr_in      = '0;
      stat_in      = STAT_REUSED;
      pop          = 1'b0;
      link_we      = 1'b0;
      link_wr_addr = item.unit;
      link_wr_data = head_rd;
      link_rd_addr = UNIT_W'(head_rd - HEAD_W'(1));

      case (state_ff)
         BK_EXEC: begin
            if (item_valid) begin
               pop = 1'b1;
               case (item.kind)
                  OP_BAD: begin
                     valid_in = 1'b1;
                     stat_in  = STAT_BADSIZE;
                  end
                  OP_IGNORE: begin
                     valid_in = 1'b1;
                     stat_in  = STAT_IGNORED;
                  end
                  OP_FREE: begin
                     link_we            = 1'b1;
                     heads_in[item.cls] = {1'b0, item.unit} + HEAD_W'(1);
                     valid_in           = 1'b1;
                     stat_in            = STAT_FREED;
                  end
                  default: begin
                     if (item.pooled && head_rd != '0) begin
                        cls_in   = item.cls;
                        unit_in  = link_rd_addr;
                        state_in = BK_LINK;
                     end else if (oom) begin
                        valid_in = 1'b1;
                        stat_in  = STAT_OOM;
                     end else begin
                        bump_in  = bump_end[SIZE_W-1:0];
                        valid_in = 1'b1;
                        addr_in  = start_pos[ADDR_W-1:0];
                        stat_in  = STAT_FRESH;
                     end
                  end
               endcase
            end
         end
         BK_LINK: begin
            heads_in[cls_ff] = link_rd_ff;
            valid_in         = 1'b1;
            addr_in          = {unit_ff, pad_zero};
            stat_in          = STAT_REUSED;
            state_in         = BK_EXEC;
         end
         default: begin
            state_in = BK_EXEC;
         end
      endcase

      rsp_valid          = valid_ff;
      rsp_result_address = addr_ff;
      rsp_status         = stat_ff;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wr_addr] <= link_wr_data;
      end
      link_rd_ff <= link_mem[link_rd_addr];
   end

   always_ff @(posedge clock) begin
      cls_ff  <= cls_in;
      unit_ff <= unit_in;
      addr_ff <= addr_in;
      stat_ff <= stat_in;
      if (reset) begin
         state_ff <= BK_EXEC;
         bump_ff  <= '0;
         valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            heads_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         bump_ff  <= bump_in;
         valid_ff <= valid_in;
         heads_ff <= heads_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/size_class_free_list_allocator.sv @@
// Size-class free-list allocator over a bump arena of byte offsets.
// Command channel: present req_* with start; the item is taken at a clock
// edge where start is high and busy is low. busy rises when the two-entry
// command queue is full.
// Result channel: rsp_valid is high for exactly one cycle with
// rsp_result_address and rsp_status; one result per item, in order. The
// receiver cannot hold results off, and the block never needs it to.
// Configuration: csr_valid/csr_ready write csr_data into register
// csr_index (0 arena capacity, 1 arena base phase); csr_ready is always high.
// Result path: a taken item is written into the command queue, and the back
// end pops it and registers its result onto the ports; an allocation served
// from a free list passes through the extra link state first, since it waits
// on the registered read of the link memory.
// Throughput: one item per cycle, except free-list reuse, which holds the back
// end in its link state for the link memory read and the class head update.
// Reset: all class lists empty, bump pointer zero, capacity 65536, phase 0,
// queue empty. The link memory is not cleared; it is only read for blocks
// that were freed, which wrote their entry.
`default_nettype none

module size_class_free_list_allocator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_command,
   input  wire logic [scfla_pkg::SIZE_W-1:0]     req_block_size,
   input  wire logic [scfla_pkg::ADDR_W-1:0]     req_block_address,
   input  wire logic                             req_has_block,
   output logic                                  rsp_valid,
   output logic [scfla_pkg::ADDR_W-1:0]          rsp_result_address,
   output logic [scfla_pkg::STAT_W-1:0]          rsp_status,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [scfla_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [scfla_pkg::CSR_DATA_W-1:0] csr_data
);
   import scfla_pkg::*;

   logic [SIZE_W-1:0]  capacity_ff, capacity_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   cfg_type            cfg;

   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     queue_not_empty;
   item_type head_item;
   logic     pop;

   always_comb begin
      csr_ready   = 1'b1;
      capacity_in = capacity_ff;
      phase_in    = phase_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ARENA_CAPACITY:   capacity_in = csr_data[SIZE_W-1:0];
            CSR_ARENA_BASE_PHASE: phase_in    = csr_data[PHASE_W-1:0];
            default:              capacity_in = capacity_ff;
         endcase
      end
      cfg.capacity = capacity_ff;
      cfg.phase    = phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         phase_ff    <= '0;
      end else begin
         capacity_ff <= capacity_in;
         phase_ff    <= phase_in;
      end
   end

   scfla_front u_front (
      .start             (start),
      .queue_full        (queue_full),
      .req_command       (req_command),
      .req_block_size    (req_block_size),
      .req_block_address (req_block_address),
      .req_has_block     (req_has_block),
      .busy              (busy),
      .push              (push),
      .push_item         (push_item)
   );

   scfla_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   scfla_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .item_valid         (queue_not_empty),
      .item               (head_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status)
   );

endmodule

`default_nettype wire

@@ verif/tb_size_class_free_list_allocator.sv @@
`default_nettype none

module tb_size_class_free_list_allocator;
   import scfla_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int OPENING_ROWS = 23;
   localparam int ARENA_PHASES = 5;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [STAT_W-1:0] status;
   } reply_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } block_type;

   typedef struct packed {
      logic              cmd;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
      logic              hb;
      logic              known;
      reply_type         reply;
   } opening_row_type;

   localparam opening_row_type OPENING [OPENING_ROWS] = '{
      '{CMD_ALLOC, 17'd0,     16'd0,     1'b0, 1'b1, '{16'd0,     STAT_BADSIZE}},
      '{CMD_ALLOC, 17'd24,    16'd0,     1'b0, 1'b1, '{16'd0,     STAT_BADSIZE}},
      '{CMD_ALLOC, 17'd16,    16'd0,     1'b0, 1'b1, '{16'd0,     STAT_FRESH}},
      '{CMD_ALLOC, 17'd256,   16'd0,     1'b0, 1'b1, '{16'd16,    STAT_FRESH}},
      '{CMD_ALLOC, 17'd272,   16'd0,     1'b0, 1'b1, '{16'd272,   STAT_FRESH}},
      '{CMD_ALLOC, 17'd65536, 16'hFFFF,  1'b1, 1'b1, '{16'd0,     STAT_OOM}},
      '{CMD_FREE,  17'd16,    16'd0,     1'b1, 1'b1, '{16'd0,     STAT_FREED}},
      '{CMD_ALLOC, 17'd16,    16'd0,     1'b0, 1'b1, '{16'd0,     STAT_REUSED}},
      '{CMD_FREE,  17'd16,    16'd0,     1'b0, 1'b1, '{16'd0,     STAT_IGNORED}},
      '{CMD_FREE,  17'd272,   16'd272,   1'b1, 1'b1, '{16'd0,     STAT_IGNORED}},
      '{CMD_FREE,  17'd65536, 16'hFFFF,  1'b1, 1'b1, '{16'd0,     STAT_IGNORED}},
      '{CMD_FREE,  17'd0,     16'd0,     1'b1, 1'b1, '{16'd0,     STAT_BADSIZE}},
      '{CMD_FREE,  17'd40,    16'd16,    1'b1, 1'b1, '{16'd0,     STAT_BADSIZE}},
      '{CMD_FREE,  17'd256,   16'd16,    1'b1, 1'b1, '{16'd0,     STAT_FREED}},
      '{CMD_FREE,  17'd256,   16'hFFFF,  1'b1, 1'b1, '{16'd0,     STAT_FREED}},
      '{CMD_ALLOC, 17'd256,   16'd0,     1'b0, 1'b0, '0},
      '{CMD_ALLOC, 17'd256,   16'd0,     1'b0, 1'b0, '0},
      '{CMD_ALLOC, 17'd256,   16'd0,     1'b0, 1'b0, '0},
      '{CMD_FREE,  17'd144,   16'd544,   1'b1, 1'b0, '0},
      '{CMD_FREE,  17'd144,   16'd544,   1'b1, 1'b0, '0},
      '{CMD_ALLOC, 17'd144,   16'd0,     1'b0, 1'b0, '0},
      '{CMD_ALLOC, 17'd144,   16'd0,     1'b0, 1'b0, '0},
      '{CMD_ALLOC, 17'd65520, 16'd0,     1'b0, 1'b1, '{16'd0,     STAT_OOM}}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_command = CMD_ALLOC;
   logic [SIZE_W-1:0]     req_block_size = '0;
   logic [ADDR_W-1:0]     req_block_address = '0;
   logic                  req_has_block = 1'b0;
   logic                  rsp_valid;
   logic [ADDR_W-1:0]     rsp_result_address;
   logic [STAT_W-1:0]     rsp_status;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ARENA_CAPACITY;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic      row_known = 1'b0;
   reply_type row_reply = '0;
   logic      row_tracked = 1'b0;

   logic [HEAD_W-1:0]  class_head [NUM_CLASSES];
   logic [HEAD_W-1:0]  next_link [LINK_DEPTH];
   logic [SIZE_W-1:0]  bump_mark;
   logic [SIZE_W-1:0]  capacity;
   logic [PHASE_W-1:0] base_phase;

   reply_type replies_due [$];
   block_type live_blocks [$];
   int        failures = 0;
   int        items_taken = 0;
   int        settings_used = 1;
   int        status_seen [8];
   int        burst_left = 0;
   int        cycles = 0;

   wire item_taken = start && (busy === 1'b0);

   size_class_free_list_allocator dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_block_size     (req_block_size),
      .req_block_address  (req_block_address),
      .req_has_block      (req_has_block),
      .rsp_valid          (rsp_valid),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned phase_pad(input int unsigned pos);
      int unsigned mis;
      mis = (int'(base_phase) + pos) % ALIGN_BYTES;
      return (mis != 0) ? ALIGN_BYTES - mis : 0;
   endfunction

   function automatic reply_type allocator_step(input logic cmd, input logic [SIZE_W-1:0] size,
                                                input logic [ADDR_W-1:0] addr, input logic hb);
      reply_type   r;
      int unsigned sz;
      int unsigned cls;
      int unsigned unit;
      int unsigned lim;
      int unsigned first;
      logic        aligned;
      r = '0;
      sz = 32'(size);
      unit = 32'(addr) / ALIGN_BYTES;
      aligned = (sz != 0) && (sz % ALIGN_BYTES == 0);
      cls = sz / ALIGN_BYTES - 1;
      if (cmd == CMD_ALLOC) begin
         if (!aligned) begin
            r.status = STAT_BADSIZE;
         end else if (sz <= MAX_POOLED_BYTES && class_head[cls] != '0) begin
            unit = 32'(class_head[cls]) - 1;
            class_head[cls] = next_link[unit];
            r.addr = ADDR_W'(unit * ALIGN_BYTES + phase_pad(0));
            r.status = STAT_REUSED;
         end else begin
            lim = (32'(capacity) > ARENA_BYTES) ? ARENA_BYTES : 32'(capacity);
            first = 32'(bump_mark) + phase_pad(32'(bump_mark));
            if (first > lim || sz > lim - first) begin
               r.status = STAT_OOM;
            end else begin
               bump_mark = SIZE_W'(first + sz);
               r.addr = ADDR_W'(first);
               r.status = STAT_FRESH;
            end
         end
      end else if (!hb || sz > MAX_POOLED_BYTES) begin
         r.status = STAT_IGNORED;
      end else if (!aligned) begin
         r.status = STAT_BADSIZE;
      end else begin
         next_link[unit] = class_head[cls];
         class_head[cls] = HEAD_W'(unit + 1);
         r.status = STAT_FREED;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (replies_due.size() == 0) begin
               $display("%0t unexpected result: address %0d status %0d", $time,
                        rsp_result_address, rsp_status);
               failures++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_result_address !== want.addr) begin
                  $display("%0t address mismatch: expected %0d actual %0d", $time,
                           want.addr, rsp_result_address);
                  failures++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t status mismatch: expected %0d actual %0d", $time,
                           want.status, rsp_status);
                  failures++;
               end
            end
         end
         if (item_taken) begin
            got = allocator_step(req_command, req_block_size, req_block_address, req_has_block);
            if (row_known) got = row_reply;
            replies_due.push_back(got);
            items_taken++;
            status_seen[got.status]++;
            if (row_tracked && (got.status == STAT_REUSED || got.status == STAT_FRESH) &&
                req_block_size <= POOLED_LIMIT)
               live_blocks.push_back('{got.addr, req_block_size});
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL size_class_free_list_allocator");
      $finish;
   end

   task automatic issue(input logic cmd, input logic [SIZE_W-1:0] size,
                        input logic [ADDR_W-1:0] addr, input logic hb,
                        input logic known, input reply_type reply, input logic tracked);
      req_command       <= cmd;
      req_block_size    <= size;
      req_block_address <= addr;
      req_has_block     <= hb;
      row_known         <= known;
      row_reply         <= reply;
      row_tracked       <= tracked;
      start             <= 1'b1;
      do @(posedge clock); while (!item_taken);
   endtask

   task automatic pace(input logic quiet);
      int gap;
      if (quiet) begin
         start <= 1'b0;
         @(posedge clock);
         while (replies_due.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
      end else if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_ARENA_CAPACITY) capacity = data;
      else base_phase = data[PHASE_W-1:0];
   endtask

   task automatic set_arena(input int phase_no);
      int unsigned cap;
      int unsigned ph;
      case (phase_no)
         1: begin
            cap = ARENA_BYTES;
            ph = 15;
         end
         2: begin
            cap = 32'(bump_mark) + $urandom_range(0, 1024);
            if (cap > ARENA_BYTES) cap = ARENA_BYTES;
            ph = $urandom_range(1, 14);
         end
         3: begin
            cap = 0;
            ph = 7;
         end
         default: begin
            cap = ARENA_BYTES;
            ph = 0;
         end
      endcase
      write_register(CSR_ARENA_CAPACITY, CSR_DATA_W'(cap));
      write_register(CSR_ARENA_BASE_PHASE, CSR_DATA_W'(ph));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic random_item();
      int unsigned       pick;
      int unsigned       k;
      logic              cmd;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
      logic              hb;
      block_type         blk;
      pick = $urandom_range(0, 99);
      cmd  = CMD_ALLOC;
      size = SIZE_W'(ALIGN_BYTES * $urandom_range(1, NUM_CLASSES));
      addr = ADDR_W'($urandom_range(0, 65535));
      hb   = 1'($urandom_range(0, 1));
      if (pick < 45) begin
      end else if (pick < 75) begin
         if (live_blocks.size() > 0) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            blk = live_blocks[k];
            live_blocks.delete(k);
            cmd  = CMD_FREE;
            size = blk.size;
            addr = blk.addr;
            hb   = 1'b1;
         end
      end else if (pick < 79) begin
         size = SIZE_W'(ALIGN_BYTES * $urandom_range(NUM_CLASSES + 1, 2 * NUM_CLASSES));
      end else if (pick == 79) begin
         size = SIZE_W'(ALIGN_BYTES * $urandom_range(2 * NUM_CLASSES + 1, ARENA_BYTES / ALIGN_BYTES));
      end else if (pick < 85) begin
         if ($urandom_range(0, 9) == 0) size = '0;
         else size = SIZE_W'(ALIGN_BYTES * $urandom_range(0, 4095) +
                             $urandom_range(1, ALIGN_BYTES - 1));
      end else if (pick < 91) begin
         cmd = CMD_FREE;
         if ($urandom_range(0, 1) == 0) size = SIZE_W'($urandom_range(0, ARENA_BYTES));
      end else if (pick < 95) begin
         cmd  = CMD_FREE;
         hb   = 1'b0;
         size = SIZE_W'($urandom_range(0, ARENA_BYTES));
      end else begin
         cmd = CMD_FREE;
         hb  = 1'b1;
         if ($urandom_range(0, 7) == 0) size = '0;
         else size = SIZE_W'(ALIGN_BYTES * $urandom_range(0, NUM_CLASSES - 1) +
                             $urandom_range(1, ALIGN_BYTES - 1));
      end
      issue(cmd, size, addr, hb, 1'b0, '0, 1'b1);
   endtask

   initial begin
      int count;
      foreach (class_head[i]) class_head[i] = '0;
      foreach (next_link[i]) next_link[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      bump_mark  = '0;
      capacity   = CAPACITY_RESET;
      base_phase = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < OPENING_ROWS; n++) begin
         issue(OPENING[n].cmd, OPENING[n].size, OPENING[n].addr, OPENING[n].hb,
               OPENING[n].known, OPENING[n].reply, 1'b0);
         pace(n == OPENING_ROWS - 1);
      end
      for (int p = 0; p < ARENA_PHASES; p++) begin
         if (p > 0) set_arena(p);
         count = (p == 0) ? 170 : 190;
         for (int n = 0; n < count; n++) begin
            random_item();
            pace(n == count - 1 || $urandom_range(0, 99) == 0);
         end
      end
      $display("%0d items over %0d arena settings: %0d reused, %0d fresh, %0d out of memory",
               items_taken, settings_used, status_seen[STAT_REUSED], status_seen[STAT_FRESH],
               status_seen[STAT_OOM]);
      $display("%0d freed, %0d frees ignored, %0d bad sizes, %0d mismatches",
               status_seen[STAT_FREED], status_seen[STAT_IGNORED], status_seen[STAT_BADSIZE],
               failures);
      if (failures == 0) begin
         $display("PASS size_class_free_list_allocator");
      end else begin
         $display("FAIL size_class_free_list_allocator");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/scfla_pkg.sv
rtl/core/scfla_front.sv
rtl/core/scfla_queue.sv
rtl/core/scfla_back.sv
rtl/core/size_class_free_list_allocator.sv
verif/tb_size_class_free_list_allocator.sv
